@@ rtl/core/mad_pkg.sv @@
// Shared types and constants for the modular aggregate decrypt core.
package mad_pkg;

    // Field widths
    localparam int Q_W    = 62;
    localparam int T_W    = 32;
    localparam int SLOT_W = 12;
    localparam int FUNC_W = 2;
    localparam int DATA_W = 64;
    localparam int ADDR_W = 4;

    // Remainder datapath: one bit of headroom over q so that q = 2^62 fits
    typedef logic [Q_W:0]   t_wide;
    typedef logic [T_W:0]   t_tmod;
    typedef logic [5:0]     t_step;
    typedef logic [FUNC_W-1:0] t_func;

    // Input function codes
    localparam t_func FUNC_APPEND = 2'd0;
    localparam t_func FUNC_BEGIN  = 2'd1;
    localparam t_func FUNC_ADD    = 2'd2;

    // Register select bit of paddr (registers sit at byte offsets 0 and 8)
    localparam int   REG_SEL_BIT = 3;
    localparam logic REG_Q       = 1'b0;
    localparam logic REG_T       = 1'b1;

    // Reset values of the configuration registers
    localparam logic [Q_W-1:0] Q_RESET = 62'd1152921504606846977;
    localparam logic [T_W-1:0] T_RESET = 32'd65537;

    // Moduli used when the register holds zero
    localparam t_wide Q_ZERO_EFF = 63'h4000_0000_0000_0000;
    localparam t_tmod T_ZERO_EFF = 33'h1_0000_0000;

    // Last step index of a 63-bit shift-subtract remainder pass
    localparam t_step DIV_LAST = 6'd62;

endpackage

@@ rtl/core/modular_aggregate_decrypt_core.sv @@
// Modular aggregate decrypt core: mask table, modular accumulator and decrypt sequencer.
// Steps: append, unused codes and a non-last bad-index begin finish in the idle state; a good begin
//   reads the mask table; an add runs one 63-step shift-subtract pass of the shared unit modulo q.
// A last good begin next runs a 63-step pass modulo q on the read value. A last item then adds
//   a centring step, a 63-step pass modulo t, a fix-up step and a result step; a last bad begin
//   or a last add in an errored run goes straight to the result step with a zero sum and error status,
//   and the result step waits until the previous result is taken. One request at a time, taken while idle.
// Reset: synchronous active low; clears entry count, accumulator, error flag, output valid,
//   and loads the default moduli. Mask table contents are not cleared.
module modular_aggregate_decrypt_core #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [mad_pkg::FUNC_W-1:0]      i_func,
    input  logic [mad_pkg::SLOT_W-1:0]      i_slot_index,
    input  logic [mad_pkg::Q_W-1:0]         i_operand,
    input  logic                            i_last,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [mad_pkg::T_W-1:0]         o_plain_sum,
    output logic                            o_status,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mad_pkg::ADDR_W-1:0]      paddr,
    input  logic [mad_pkg::DATA_W-1:0]      pwdata,
    output logic [mad_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);

    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (CW > mad_pkg::SLOT_W) ? CW : mad_pkg::SLOT_W;

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DADD  = 3'd2;
    localparam logic [2:0] ST_DRAW  = 3'd3;
    localparam logic [2:0] ST_CENT  = 3'd4;
    localparam logic [2:0] ST_DMODT = 3'd5;
    localparam logic [2:0] ST_FIX   = 3'd6;
    localparam logic [2:0] ST_EMIT  = 3'd7;

    // Mask table
    logic [mad_pkg::Q_W-1:0] mem [TABLE_DEPTH];
    logic [mad_pkg::Q_W-1:0] r_rdata;
    logic                    mem_we;
    logic                    mem_re;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;

    // Control state
    logic [2:0]              r_state, n_state;
    logic [CW-1:0]           r_count, n_count;
    logic [mad_pkg::Q_W-1:0] r_acc, n_acc;
    logic                    r_err, n_err;
    logic                    r_out_valid, n_out_valid;
    logic [mad_pkg::Q_W-1:0] r_q;
    logic [mad_pkg::T_W-1:0] r_t;

    // Datapath state
    logic                    r_last, n_last;
    logic                    r_neg, n_neg;
    mad_pkg::t_wide          r_rem, n_rem;
    mad_pkg::t_wide          r_dvd, n_dvd;
    mad_pkg::t_wide          r_dvs, n_dvs;
    mad_pkg::t_step          r_cnt, n_cnt;
    logic [mad_pkg::T_W-1:0] r_res, n_res;
    logic                    r_stat, n_stat;
    logic [mad_pkg::T_W-1:0] r_osum, n_osum;
    logic                    r_ostat, n_ostat;

    // Derived values
    mad_pkg::t_wide          q_eff;
    mad_pkg::t_wide          q_half;
    mad_pkg::t_tmod          t_eff;
    mad_pkg::t_wide          rem_sh;
    logic [mad_pkg::Q_W+1:0] rem_diff;
    mad_pkg::t_wide          rem_nx;
    mad_pkg::t_wide          cent_mag;
    logic                    cent_neg;
    mad_pkg::t_tmod          fix_val;
    logic                    in_fire;
    logic                    out_take;
    logic                    slot_bad;
    logic                    can_append;
    logic                    div_busy;
    logic                    cfg_wr;

    // Effective moduli
    assign q_eff  = (r_q == '0) ? mad_pkg::Q_ZERO_EFF : {1'b0, r_q};
    assign q_half = q_eff >> 1;
    assign t_eff  = (r_t == '0) ? mad_pkg::T_ZERO_EFF : {1'b0, r_t};

    // Shared shift-subtract remainder step
    assign rem_sh   = {r_rem[mad_pkg::Q_W-1:0], r_dvd[mad_pkg::Q_W]};
    assign rem_diff = {1'b0, rem_sh} - {1'b0, r_dvs};
    assign rem_nx   = rem_diff[mad_pkg::Q_W+1] ? rem_sh : rem_diff[mad_pkg::Q_W:0];

    // Centring and final fix-up
    assign cent_neg = r_rem > q_half;
    assign cent_mag = q_eff - r_rem;
    assign fix_val  = t_eff - r_rem[mad_pkg::T_W:0];

    // Handshakes and checks
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_take   = r_out_valid && i_out_ready;
    assign slot_bad   = CMPW'(i_slot_index) >= CMPW'(r_count);
    assign can_append = r_count < CW'(TABLE_DEPTH);
    assign div_busy   = (r_state == ST_DADD) || (r_state == ST_DRAW) || (r_state == ST_DMODT);
    assign wr_addr    = r_count[AW-1:0];
    assign rd_addr    = AW'(i_slot_index);
    assign cfg_wr     = psel && penable && pwrite && pready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_acc       = r_acc;
        n_err       = r_err;
        n_out_valid = r_out_valid;
        n_last      = r_last;
        n_neg       = r_neg;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_stat      = r_stat;
        n_osum      = r_osum;
        n_ostat     = r_ostat;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        // drop the result once taken
        if (out_take) begin
            n_out_valid = 1'b0;
        end

        // advance the remainder unit one bit
        if (div_busy) begin
            n_rem = rem_nx;
            n_dvd = {r_dvd[mad_pkg::Q_W-1:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_last = i_last;
                    unique case (i_func)
                        mad_pkg::FUNC_APPEND: begin
                            if (can_append) begin
                                mem_we  = 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        mad_pkg::FUNC_BEGIN: begin
                            if (slot_bad) begin
                                n_err = 1'b1;
                                n_acc = '0;
                                if (i_last) begin
                                    n_res   = '0;
                                    n_stat  = 1'b1;
                                    n_state = ST_EMIT;
                                end
                            end else begin
                                n_err   = 1'b0;
                                mem_re  = 1'b1;
                                n_state = ST_READ;
                            end
                        end
                        mad_pkg::FUNC_ADD: begin
                            n_dvd   = {1'b0, r_acc} + {1'b0, i_operand};
                            n_dvs   = q_eff;
                            n_rem   = '0;
                            n_cnt   = mad_pkg::DIV_LAST;
                            n_state = ST_DADD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                n_acc = r_rdata;
                if (r_last) begin
                    n_dvd   = {1'b0, r_rdata};
                    n_dvs   = q_eff;
                    n_rem   = '0;
                    n_cnt   = mad_pkg::DIV_LAST;
                    n_state = ST_DRAW;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DADD: begin
                if (r_cnt == '0) begin
                    n_acc = rem_nx[mad_pkg::Q_W-1:0];
                    if (!r_last) begin
                        n_state = ST_IDLE;
                    end else if (r_err) begin
                        n_res   = '0;
                        n_stat  = 1'b1;
                        n_state = ST_EMIT;
                    end else begin
                        n_state = ST_CENT;
                    end
                end
            end
            ST_DRAW: begin
                if (r_cnt == '0) begin
                    n_state = ST_CENT;
                end
            end
            ST_CENT: begin
                n_neg   = cent_neg;
                n_dvd   = cent_neg ? cent_mag : r_rem;
                n_dvs   = {{(mad_pkg::Q_W - mad_pkg::T_W){1'b0}}, t_eff};
                n_rem   = '0;
                n_cnt   = mad_pkg::DIV_LAST;
                n_state = ST_DMODT;
            end
            ST_DMODT: begin
                if (r_cnt == '0) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                // negative centred value maps to t - r unless r is zero
                if (r_neg && (r_rem[mad_pkg::T_W:0] != '0)) begin
                    n_res = fix_val[mad_pkg::T_W-1:0];
                end else begin
                    n_res = r_rem[mad_pkg::T_W-1:0];
                end
                n_stat  = 1'b0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_osum      = r_res;
                    n_ostat     = r_stat;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers and configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
            r_q         <= mad_pkg::Q_RESET;
            r_t         <= mad_pkg::T_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                if (paddr[mad_pkg::REG_SEL_BIT] == mad_pkg::REG_T) begin
                    r_t <= pwdata[mad_pkg::T_W-1:0];
                end else begin
                    r_q <= pwdata[mad_pkg::Q_W-1:0];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_last  <= n_last;
        r_neg   <= n_neg;
        r_rem   <= n_rem;
        r_dvd   <= n_dvd;
        r_dvs   <= n_dvs;
        r_cnt   <= n_cnt;
        r_res   <= n_res;
        r_stat  <= n_stat;
        r_osum  <= n_osum;
        r_ostat <= n_ostat;
    end

    // Mask table write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_operand;
        end
        if (mem_re) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Outputs
    assign o_out_valid = r_out_valid;
    assign o_plain_sum = r_osum;
    assign o_status    = r_ostat;
    assign pready      = 1'b1;
    assign prdata      = (paddr[mad_pkg::REG_SEL_BIT] == mad_pkg::REG_T)
                       ? {{(mad_pkg::DATA_W - mad_pkg::T_W){1'b0}}, r_t}
                       : {{(mad_pkg::DATA_W - mad_pkg::Q_W){1'b0}}, r_q};

    // Entry count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    // Partial remainder stays below the divisor on every step
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_rem < r_dvs))
        else $error("partial remainder not below divisor");

    // Error results carry a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_ostat) |-> (r_osum == '0))
        else $error("error result with nonzero sum");

    // A bad begin that ends the run goes straight to the result stage
    a_bad_begin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_func == mad_pkg::FUNC_BEGIN) && slot_bad && i_last)
        |=> (r_state == ST_EMIT))
        else $error("bad begin did not emit");

endmodule
